/* hw/rtl/aald_pkg.sv */
// package: widths, opcodes, controller states and command/status types
`timescale 1ns / 1ps
package aald_pkg;
    localparam int COORD_BITS    = 10;
    localparam int SUBPIXEL_BITS = 4;
    localparam int FRAC_BITS     = 16;
    localparam int INT_BITS      = 8;
    localparam int IN_BITS       = COORD_BITS + SUBPIXEL_BITS;   // 14
    localparam int WIN_BITS      = COORD_BITS + 1;               // 11
    localparam int SLOPE_BITS    = FRAC_BITS + 2;                // signed 1.16
    localparam int MINOR_BITS    = IN_BITS + FRAC_BITS - SUBPIXEL_BITS + 2; // 28
    localparam int GAP_BITS      = SUBPIXEL_BITS + 2;            // 0..32
    localparam int DIV_STEPS     = IN_BITS + FRAC_BITS;          // 30
    localparam int CNT_BITS      = $clog2(DIV_STEPS);
    localparam logic [WIN_BITS-1:0] WIN_RESET = WIN_BITS'(1 << COORD_BITS);

    typedef enum logic {
        OP_BEGIN   = 1'b0,
        OP_ADVANCE = 1'b1
    } t_opcode;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg_index;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_END0     = 2'd1,
        PH_END1     = 2'd2,
        PH_INTERIOR = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_EP0,
        S_EP1,
        S_PIX0,
        S_PIX1
    } t_state;

    typedef struct packed {
        logic load_begin;
        logic load_adv;
        logic div_step;
        logic ep0;
        logic ep1;
        logic emit0;
        logic emit1;
    } t_dp_cmd;

    typedef struct packed {
        logic in_dx_zero;
        logic div_last;
        logic out_free;
        logic line_active;
    } t_dp_status;
endpackage

/* hw/rtl/aald_regs.sv */
// window size registers behind the apb-style port
`timescale 1ns / 1ps
module aald_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [aald_pkg::WIN_BITS-1:0] o_win_width,
    output logic [aald_pkg::WIN_BITS-1:0] o_win_height
);
    import aald_pkg::*;

    logic [WIN_BITS-1:0] r_width, r_height;
    logic                wr;
    t_reg_index          idx;

    assign pready = 1'b1;
    assign wr     = psel & penable & pwrite;
    assign idx    = t_reg_index'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIN_RESET;
            r_height <= WIN_RESET;
        end else if (wr) begin
            case (idx)
                REG_WIDTH:  r_width  <= pwdata[WIN_BITS-1:0];
                REG_HEIGHT: r_height <= pwdata[WIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_WIDTH:  prdata = {{(32-WIN_BITS){1'b0}}, r_width};
            REG_HEIGHT: prdata = {{(32-WIN_BITS){1'b0}}, r_height};
            default:    prdata = '0;
        endcase
    end

    assign o_win_width  = r_width;
    assign o_win_height = r_height;
endmodule

/* hw/rtl/aald_ctrl.sv */
// controller: sequences line setup, gradient division and pixel emission
`timescale 1ns / 1ps
module aald_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_op,
    output logic                 o_in_ready,
    input  aald_pkg::t_dp_status i_status,
    output aald_pkg::t_dp_cmd    o_cmd
);
    import aald_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (t_opcode'(i_in_op) == OP_BEGIN) begin
                        o_cmd.load_begin = 1'b1;
                        n_state = i_status.in_dx_zero ? S_EP0 : S_DIV;
                    end else if (i_status.line_active) begin
                        o_cmd.load_adv = 1'b1;
                        n_state = S_PIX0;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) n_state = S_EP0;
            end
            S_EP0: begin
                o_cmd.ep0 = 1'b1;
                n_state = S_EP1;
            end
            S_EP1: begin
                o_cmd.ep1 = 1'b1;
                n_state = S_IDLE;
            end
            S_PIX0: begin
                if (i_status.out_free) begin
                    o_cmd.emit0 = 1'b1;
                    n_state = S_PIX1;
                end
            end
            S_PIX1: begin
                if (i_status.out_free) begin
                    o_cmd.emit1 = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* hw/rtl/aald_dp.sv */
// datapath: endpoint setup, restoring divider, column stepping, pixel output register
`timescale 1ns / 1ps
module aald_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [55:0]                   i_in_data,
    input  logic [aald_pkg::WIN_BITS-1:0] i_win_width,
    input  logic [aald_pkg::WIN_BITS-1:0] i_win_height,
    input  aald_pkg::t_dp_cmd             i_cmd,
    output aald_pkg::t_dp_status          o_status,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [31:0]                   o_out_data,
    output logic                          o_out_last
);
    import aald_pkg::*;

    // ---- begin: steepness, swap and order
    logic [IN_BITS-1:0] ax, ay, bx, by, sx0, sy0, sx1, sy1, adx, ady;
    logic [IN_BITS-1:0] ox0, oy0, ox1, oy1, in_dx;
    logic               steep;

    assign ax  = i_in_data[IN_BITS-1:0];
    assign ay  = i_in_data[2*IN_BITS-1:IN_BITS];
    assign bx  = i_in_data[3*IN_BITS-1:2*IN_BITS];
    assign by  = i_in_data[4*IN_BITS-1:3*IN_BITS];
    assign adx = (bx > ax) ? bx - ax : ax - bx;
    assign ady = (by > ay) ? by - ay : ay - by;
    assign steep = ady > adx;

    always_comb begin
        sx0 = steep ? ay : ax;  sy0 = steep ? ax : ay;
        sx1 = steep ? by : bx;  sy1 = steep ? bx : by;
        if (sx0 > sx1) begin
            ox0 = sx1; oy0 = sy1; ox1 = sx0; oy1 = sy0;
        end else begin
            ox0 = sx0; oy0 = sy0; ox1 = sx1; oy1 = sy1;
        end
    end
    assign in_dx = ox1 - ox0;

    logic [IN_BITS-1:0]   r_x0, r_y0, r_x1, r_y1, r_dx;
    logic                 r_swap, r_dy_neg, r_dx_zero;
    logic [IN_BITS:0]     r_rem;
    logic [DIV_STEPS-1:0] r_num;
    logic [FRAC_BITS:0]   r_quo;
    logic [CNT_BITS-1:0]  r_cnt;
    logic [IN_BITS:0]     div_t;
    logic                 div_ge;

    assign div_t  = {r_rem[IN_BITS-1:0], r_num[DIV_STEPS-1]};
    assign div_ge = div_t >= {1'b0, r_dx};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_begin) begin
            r_swap    <= steep;
            r_x0 <= ox0; r_y0 <= oy0; r_x1 <= ox1; r_y1 <= oy1;
            r_dx      <= in_dx;
            r_dx_zero <= (in_dx == '0);
            r_dy_neg  <= oy1 < oy0;
            r_num     <= {((oy1 < oy0) ? oy0 - oy1 : oy1 - oy0), {FRAC_BITS{1'b0}}};
            r_rem     <= '0;
            r_quo     <= '0;
            r_cnt     <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? div_t - {1'b0, r_dx} : div_t;
            r_quo <= {r_quo[FRAC_BITS-1:0], div_ge};
            r_num <= {r_num[DIV_STEPS-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    // gradient, held stable for the whole line
    logic signed [SLOPE_BITS-1:0] slope;
    always_comb begin
        if (r_dx_zero)     slope = SLOPE_BITS'(1 << FRAC_BITS);
        else if (r_dy_neg) slope = -$signed({1'b0, r_quo});
        else               slope = $signed({1'b0, r_quo});
    end

    // ---- endpoint setup, one endpoint per cycle
    logic [IN_BITS-1:0]            ep_x, ep_y;
    logic [IN_BITS+1:0]            ep_tt;
    logic [WIN_BITS-1:0]           ep_xr;
    logic [SUBPIXEL_BITS:0]        ep_fr;
    logic signed [IN_BITS+1:0]     ep_dfull;
    logic signed [SUBPIXEL_BITS:0] ep_d;
    logic signed [SLOPE_BITS+SUBPIXEL_BITS:0] ep_prod;
    logic signed [MINOR_BITS-1:0]  ep_minor;
    logic [GAP_BITS-1:0]           ep_gap;

    assign ep_x     = i_cmd.ep1 ? r_x1 : r_x0;
    assign ep_y     = i_cmd.ep1 ? r_y1 : r_y0;
    assign ep_tt    = {1'b0, ep_x, 1'b0} + (IN_BITS+2)'(1 << SUBPIXEL_BITS);
    assign ep_xr    = ep_tt[IN_BITS+1:SUBPIXEL_BITS+1];
    assign ep_fr    = ep_tt[SUBPIXEL_BITS:0];
    assign ep_dfull = $signed({1'b0, ep_xr, {SUBPIXEL_BITS{1'b0}}}) - $signed({2'b0, ep_x});
    assign ep_d     = ep_dfull[SUBPIXEL_BITS:0];
    assign ep_prod  = slope * ep_d;
    assign ep_minor = $signed({2'b0, ep_y, {(FRAC_BITS-SUBPIXEL_BITS){1'b0}}})
                    + MINOR_BITS'(ep_prod >>> SUBPIXEL_BITS);
    assign ep_gap   = i_cmd.ep1 ? {1'b0, ep_fr}
                                : GAP_BITS'(2 << SUBPIXEL_BITS) - {1'b0, ep_fr};

    logic signed [MINOR_BITS-1:0] r_em_minor0, r_acc;
    logic [GAP_BITS-1:0]          r_em_gap0, r_em_gap1;
    logic [WIN_BITS-1:0]          r_em_major0, r_em_major1, r_mpos, r_mlim;
    logic signed [MINOR_BITS-1:0] r_em_minor1;
    logic                         r_active;
    t_phase                       r_phase;

    // ---- column registers
    logic [WIN_BITS-1:0]          r_col_major;
    logic signed [MINOR_BITS-1:0] r_col_minor;
    logic [GAP_BITS-1:0]          r_col_gap;
    logic                         r_col_ep, r_col_final;
    logic [WIN_BITS:0]            mpos_inc;

    assign mpos_inc = {1'b0, r_mpos} + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_phase  <= PH_IDLE;
        end else if (i_cmd.ep1) begin
            r_active <= 1'b1;
            r_phase  <= PH_END0;
        end else if (i_cmd.load_adv) begin
            case (r_phase)
                PH_END0: r_phase <= PH_END1;
                PH_END1: begin
                    if (r_mpos >= r_mlim) begin
                        r_active <= 1'b0;
                        r_phase  <= PH_IDLE;
                    end else begin
                        r_phase  <= PH_INTERIOR;
                    end
                end
                PH_INTERIOR: begin
                    if (mpos_inc >= {1'b0, r_mlim}) begin
                        r_active <= 1'b0;
                        r_phase  <= PH_IDLE;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ep0) begin
            r_em_minor0 <= ep_minor;
            r_em_gap0   <= ep_gap;
            r_em_major0 <= ep_xr;
        end
        if (i_cmd.ep1) begin
            r_em_minor1 <= ep_minor;
            r_em_gap1   <= ep_gap;
            r_em_major1 <= ep_xr;
            r_acc       <= r_em_minor0 + MINOR_BITS'(slope);
            r_mpos      <= r_em_major0 + 1'b1;
            r_mlim      <= ep_xr;
        end
        if (i_cmd.load_adv) begin
            case (r_phase)
                PH_END0: begin
                    r_col_major <= r_em_major0;  r_col_minor <= r_em_minor0;
                    r_col_gap   <= r_em_gap0;    r_col_ep    <= 1'b1;
                    r_col_final <= 1'b0;
                end
                PH_END1: begin
                    r_col_major <= r_em_major1;  r_col_minor <= r_em_minor1;
                    r_col_gap   <= r_em_gap1;    r_col_ep    <= 1'b1;
                    r_col_final <= r_mpos >= r_mlim;
                end
                default: begin
                    r_col_major <= r_mpos;       r_col_minor <= r_acc;
                    r_col_gap   <= GAP_BITS'(1); r_col_ep    <= 1'b0;
                    r_col_final <= mpos_inc >= {1'b0, r_mlim};
                    r_acc       <= r_acc + MINOR_BITS'(slope);
                    r_mpos      <= mpos_inc[WIN_BITS-1:0];
                end
            endcase
        end
    end

    // ---- pixel evaluation for the column's two pixels
    localparam int IP_BITS = MINOR_BITS - FRAC_BITS;
    localparam int CN_BITS = FRAC_BITS + 1 + GAP_BITS;
    logic signed [IP_BITS-1:0] ip0, ip1;
    logic [FRAC_BITS:0]        f, rf, wgt;
    logic [CN_BITS-1:0]        cnum;
    logic [CN_BITS+INT_BITS-1:0] cscaled, cshift;
    logic [INT_BITS-1:0]       cov;
    logic [IP_BITS-1:0]        maj_w, px0, py0, px1, py1, px, py;
    logic                      vis0, vis1;

    function automatic logic visible(input logic [IP_BITS-1:0] x,
                                     input logic [IP_BITS-1:0] y,
                                     input logic [WIN_BITS-1:0] w,
                                     input logic [WIN_BITS-1:0] h);
        logic [IP_BITS-1:0] lim;
        lim = IP_BITS'(1 << COORD_BITS);
        visible = !x[IP_BITS-1] && !y[IP_BITS-1] && (x < lim) && (y < lim)
               && (x < IP_BITS'(w)) && (y < IP_BITS'(h));
    endfunction

    assign ip0   = r_col_minor[MINOR_BITS-1:FRAC_BITS];
    assign ip1   = ip0 + 1'b1;
    assign f     = {1'b0, r_col_minor[FRAC_BITS-1:0]};
    assign rf    = (FRAC_BITS+1)'(1 << FRAC_BITS) - f;
    assign maj_w = IP_BITS'(r_col_major);
    assign px0   = r_swap ? ip0 : maj_w;
    assign py0   = r_swap ? maj_w : ip0;
    assign px1   = r_swap ? ip1 : maj_w;
    assign py1   = r_swap ? maj_w : ip1;
    assign vis0  = visible(px0, py0, i_win_width, i_win_height);
    assign vis1  = visible(px1, py1, i_win_width, i_win_height);

    assign px      = i_cmd.emit1 ? px1 : px0;
    assign py      = i_cmd.emit1 ? py1 : py0;
    assign wgt     = i_cmd.emit1 ? f : rf;
    assign cnum    = wgt * r_col_gap;
    // times the full-scale intensity
    assign cscaled = {cnum, {INT_BITS{1'b0}}} - (CN_BITS+INT_BITS)'(cnum);
    assign cshift  = r_col_ep ? cscaled >> (FRAC_BITS + SUBPIXEL_BITS + 1)
                              : cscaled >> FRAC_BITS;
    assign cov     = cshift[INT_BITS-1:0];

    // ---- output register
    logic r_out_valid, r_out_last;
    logic [COORD_BITS-1:0] r_px, r_py;
    logic [INT_BITS-1:0]   r_cov;
    logic                  out_free, do_load;

    assign out_free = !r_out_valid || i_out_ready;
    assign do_load  = (i_cmd.emit0 && vis0) || (i_cmd.emit1 && vis1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (do_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_px       <= px[COORD_BITS-1:0];
            r_py       <= py[COORD_BITS-1:0];
            r_cov      <= cov;
            r_out_last <= r_col_final && (i_cmd.emit1 || !vis1);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_out_data  = {{(32-2*COORD_BITS-INT_BITS){1'b0}}, r_cov, r_py, r_px};

    assign o_status.in_dx_zero  = (in_dx == '0);
    assign o_status.div_last    = (r_cnt == CNT_BITS'(DIV_STEPS - 1));
    assign o_status.out_free    = out_free;
    assign o_status.line_active = r_active;
endmodule

/* hw/rtl/antialiased_line_drawer.sv */
// antialiased line rasterizer: begin item sets up a line, advance item emits one column
// begin item: endpoint setup, after a 30-step gradient division unless the line has no
// major extent; advance item: up to two pixel items through a one-deep output register,
// no effect with no line active, held up while the output is stalled
// one item is worked on at a time; s_axis_tready is high only while the controller idles
// synchronous active-low reset: no line active, output empty, window registers 1024 x 1024
`timescale 1ns / 1ps
module antialiased_line_drawer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // start_x, start_y, end_x, end_y
    input  logic        s_axis_tuser,  // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // pixel_x, pixel_y, coverage, zero pad
    output logic        m_axis_tlast,  // line_done
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import aald_pkg::*;

    logic [WIN_BITS-1:0] win_width, win_height;
    t_dp_cmd             cmd;
    t_dp_status          status;

    aald_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_win_width  (win_width),
        .o_win_height (win_height)
    );

    aald_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_op    (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    aald_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_data    (s_axis_tdata),
        .i_win_width  (win_width),
        .i_win_height (win_height),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_data   (m_axis_tdata),
        .o_out_last   (m_axis_tlast)
    );
endmodule
